// ===== sv/wwbws_pkg.sv =====
// Shared constants and controller/datapath interface types for the word wrap width search.
`timescale 1ns / 1ps

package wwbws_pkg;

    // default capacity
    localparam int MAX_WORDS_DEF = 256;
    localparam int MAX_CHARS_DEF = 4096;

    // fixed field widths
    localparam int BW    = 9;   // box width
    localparam int CRW   = 13;  // reported cost
    localparam int STW   = 2;   // status
    localparam int TRI_W = 18;  // r*(r+3)/2 for r up to 499, with margin

    localparam logic [BW-1:0] WIDTH_DEFAULT = 9'd80;
    localparam logic [BW-1:0] WIDTH_CEILING = 9'd500;

    // status codes
    localparam logic [STW-1:0] ST_OK     = 2'd0;
    localparam logic [STW-1:0] ST_BLANK  = 2'd1;
    localparam logic [STW-1:0] ST_NOFIT  = 2'd2;
    localparam logic [STW-1:0] ST_OVFL   = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic load;    // take one character
        logic start;   // set up the search
        logic fetch0;  // read first word length, reset per-width state
        logic fetch1;  // read second word length
        logic word;    // place one word
        logic eval;    // compare finished width cost
        logic finish;  // register result, clear text state
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic skip;       // nothing to search
        logic last_word;  // current word is the last one
        logic stop;       // search over after this width
    } t_dp_sts;

endpackage

// ===== sv/word_wrap_best_width_search.sv =====
// Top level of the word wrap best width search: controller plus datapath.
`timescale 1ns / 1ps

// Text arrives one character word per cycle on the input channel; whitespace
// (tab, LF, VT, FF, CR, space) separates words and every other byte, zero
// included, counts as a word character. Word lengths go to an internal store
// of MAX_WORDS entries. The byte flagged by i_final_byte starts the search:
// every box width from the longest word up to min(total length, width cap)-1
// is filled greedily and scored, and the smallest width with the least cost
// is returned as one output word with a status (0 ok, 1 only blanks, 2 no
// width fits, 3 too many words or characters). Each width tried is set up,
// then filled one word at a time and evaluated, because the single read
// port of the length store delivers one word per cycle; the search ends
// early at a zero cost. Input is blocked during the search, but a finished
// result may sit in the output register while the next text loads. The width
// cap (reset 80; 0 and values above 500 act as 80) is written through
// i_cfg_wr_en/i_cfg_wr_data and should only change while the block is idle.

module word_wrap_best_width_search #(
    parameter int MAX_WORDS = wwbws_pkg::MAX_WORDS_DEF,
    parameter int MAX_CHARS = wwbws_pkg::MAX_CHARS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_wr_en,
    input  logic [wwbws_pkg::BW-1:0]  i_cfg_wr_data,
    // character input
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [7:0]                i_text_byte,
    input  logic                      i_final_byte,
    // result output
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [wwbws_pkg::BW-1:0]  o_best_width,
    output logic [wwbws_pkg::CRW-1:0] o_least_cost,
    output logic [wwbws_pkg::STW-1:0] o_status
);
    import wwbws_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer: load, set up, then per width fetch/place/evaluate
    wwbws_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_final_byte (i_final_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cmd        (cmd),
        .i_sts        (sts)
    );

    // counters, length store, cost arithmetic and result register
    wwbws_dp #(
        .MAX_WORDS (MAX_WORDS),
        .MAX_CHARS (MAX_CHARS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_text_byte   (i_text_byte),
        .i_final_byte  (i_final_byte),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_best_width  (o_best_width),
        .o_least_cost  (o_least_cost),
        .o_status      (o_status)
    );

endmodule

// ===== sv/wwbws_ctrl.sv =====
// Sequencer for loading characters and stepping the width search.
`timescale 1ns / 1ps

module wwbws_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_final_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output wwbws_pkg::t_dp_cmd o_cmd,
    input  wwbws_pkg::t_dp_sts i_sts
);
    import wwbws_pkg::*;

    typedef enum logic [6:0] {
        S_LOAD   = 7'b0000001,
        S_START  = 7'b0000010,
        S_FETCH0 = 7'b0000100,
        S_FETCH1 = 7'b0001000,
        S_WORD   = 7'b0010000,
        S_EVAL   = 7'b0100000,
        S_FINISH = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   out_free;

    assign out_free    = !r_out_vld || i_out_ready;
    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = r_out_vld;

    always_comb begin
        n_state   = r_state;
        n_out_vld = r_out_vld && !i_out_ready;
        o_cmd     = '0;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_final_byte) n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state     = i_sts.skip ? S_FINISH : S_FETCH0;
            end
            S_FETCH0: begin
                o_cmd.fetch0 = 1'b1;
                n_state      = S_FETCH1;
            end
            S_FETCH1: begin
                o_cmd.fetch1 = 1'b1;
                n_state      = S_WORD;
            end
            S_WORD: begin
                o_cmd.word = 1'b1;
                if (i_sts.last_word) n_state = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.stop ? S_FINISH : S_FETCH0;
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_vld    = 1'b1;
                    n_state      = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

// ===== sv/wwbws_dp.sv =====
// Word length store, text counters, greedy-fill cost datapath and result register.
`timescale 1ns / 1ps

module wwbws_dp #(
    parameter int MAX_WORDS = wwbws_pkg::MAX_WORDS_DEF,
    parameter int MAX_CHARS = wwbws_pkg::MAX_CHARS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [7:0]                 i_text_byte,
    input  logic                       i_final_byte,
    input  logic                       i_cfg_wr_en,
    input  logic [wwbws_pkg::BW-1:0]   i_cfg_wr_data,
    input  wwbws_pkg::t_dp_cmd         i_cmd,
    output wwbws_pkg::t_dp_sts         o_sts,
    output logic [wwbws_pkg::BW-1:0]   o_best_width,
    output logic [wwbws_pkg::CRW-1:0]  o_least_cost,
    output logic [wwbws_pkg::STW-1:0]  o_status
);
    import wwbws_pkg::*;

    localparam int AW  = $clog2(MAX_WORDS);
    localparam int WCW = $clog2(MAX_WORDS + 1);
    localparam int LW  = $clog2(MAX_CHARS + 1);
    localparam int CW  = $clog2(MAX_CHARS + MAX_WORDS);
    localparam int SW  = ((CW > TRI_W) ? CW : TRI_W) + 1;
    localparam int EW0 = (CW > BW) ? CW : BW;
    localparam int EW  = ((EW0 > LW) ? EW0 : LW) + 1;

    // text state
    logic [BW-1:0]  r_width_cap;
    logic [LW-1:0]  r_letters, n_letters;
    logic [LW-1:0]  r_open, n_open;
    logic [LW-1:0]  r_longest, n_longest;
    logic [WCW-1:0] r_words, n_words;
    logic           r_ovf, n_ovf;
    logic [LW-1:0]  open_eff;
    logic           do_close, wr_en, blank;

    // word length store
    logic [LW-1:0]  r_len_mem [MAX_WORDS];
    logic [LW-1:0]  r_rdata;
    logic [AW-1:0]  rd_addr;

    // search state
    logic [BW-1:0]   r_wd, r_limit, r_rem, r_best;
    logic [WCW-1:0]  r_k;
    logic            r_fresh;
    logic [LW-1:0]   r_cur;
    logic [CW-1:0]   r_cost, r_smallest;
    logic [TRI_W-1:0] r_term;

    logic [BW-1:0]   mw_eff, limit_c, rem_after;
    logic [CW-1:0]   total_c, cost_fin, small_next;
    logic [EW-1:0]   rem_wide;
    logic [SW-1:0]   cost_sum;
    logic [2*BW:0]   tri_prod;
    logic            brk, last_w;
    logic [STW-1:0]  status_c;

    logic [BW-1:0]   r_out_best;
    logic [CRW-1:0]  r_out_cost;
    logic [STW-1:0]  r_out_status;

    assign blank = (i_text_byte == 8'd32) || (i_text_byte >= 8'd9 && i_text_byte <= 8'd13);

    // character intake; at most one word closes per character
    always_comb begin
        n_letters = r_letters;
        n_open    = r_open;
        n_words   = r_words;
        n_longest = r_longest;
        n_ovf     = r_ovf;
        open_eff  = r_open;
        do_close  = 1'b0;
        wr_en     = 1'b0;
        if (i_cmd.load) begin
            if (!r_ovf) begin
                if (blank) begin
                    do_close = 1'b1;
                end else if (r_letters >= LW'(MAX_CHARS)) begin
                    n_ovf = 1'b1;
                end else begin
                    n_letters = r_letters + LW'(1);
                    open_eff  = r_open + LW'(1);
                end
            end
            if (i_final_byte) do_close = 1'b1;
            n_open = open_eff;
            if (do_close && open_eff != '0 && !n_ovf) begin
                if (r_words >= WCW'(MAX_WORDS)) begin
                    n_ovf = 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    n_words = r_words + WCW'(1);
                    n_open  = '0;
                    if (open_eff > r_longest) n_longest = open_eff;
                end
            end
        end
        if (i_cmd.finish) begin
            n_letters = '0;
            n_open    = '0;
            n_words   = '0;
            n_longest = '0;
            n_ovf     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_cap <= WIDTH_DEFAULT;
            r_letters   <= '0;
            r_open      <= '0;
            r_words     <= '0;
            r_longest   <= '0;
            r_ovf       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_width_cap <= i_cfg_wr_data;
            r_letters <= n_letters;
            r_open    <= n_open;
            r_words   <= n_words;
            r_longest <= n_longest;
            r_ovf     <= n_ovf;
        end
    end

    // store port: one write, one registered read
    always_comb begin
        rd_addr = '0;
        if (i_cmd.fetch1) rd_addr = AW'(1);
        else if (i_cmd.word) rd_addr = AW'(r_k + WCW'(2));
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_len_mem[r_words[AW-1:0]] <= open_eff;
        r_rdata <= r_len_mem[rd_addr];
    end

    // search bounds
    assign mw_eff  = (r_width_cap >= 9'd1 && r_width_cap <= WIDTH_CEILING) ?
                     r_width_cap : WIDTH_DEFAULT;
    assign total_c = CW'(r_letters) + CW'(r_words) - CW'(1);
    assign limit_c = (EW'(total_c) <= EW'(mw_eff)) ? BW'(total_c) : mw_eff;

    // one word placement
    assign rem_wide  = (r_fresh ? EW'(r_wd) : (EW'(r_rem) - EW'(1))) - EW'(r_cur);
    assign rem_after = rem_wide[BW-1:0];
    assign last_w    = ((r_k + WCW'(1)) == r_words);
    assign brk       = EW'(rem_after) < (EW'(r_rdata) + EW'(1));
    assign tri_prod  = (2*BW+1)'(rem_after) *
                       (2*BW+1)'({1'b0, rem_after} + (BW+1)'(3));

    // saturating accumulate of the pending line cost
    assign cost_sum   = SW'(r_cost) + SW'(r_term);
    assign cost_fin   = (cost_sum > SW'({CW{1'b1}})) ? {CW{1'b1}} : cost_sum[CW-1:0];
    assign small_next = (cost_fin < r_smallest) ? cost_fin : r_smallest;

    assign o_sts.skip      = r_ovf || (r_words == '0) || (EW'(r_longest) >= EW'(limit_c));
    assign o_sts.last_word = last_w;
    assign o_sts.stop      = (small_next == '0) ||
                             ((EW'(r_wd) + EW'(1)) >= EW'(r_limit));

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_limit    <= limit_c;
            r_wd       <= BW'(r_longest);
            r_best     <= '0;
            r_smallest <= total_c;
        end
        if (i_cmd.fetch0) begin
            r_k     <= '0;
            r_fresh <= 1'b1;
            r_rem   <= r_wd;
            r_cost  <= '0;
            r_term  <= '0;
        end
        if (i_cmd.fetch1) begin
            r_cur <= r_rdata;
        end
        if (i_cmd.word) begin
            r_cur  <= r_rdata;
            r_k    <= r_k + WCW'(1);
            r_cost <= cost_fin;
            if (last_w) begin
                r_term <= TRI_W'(rem_after);
            end else if (brk) begin
                r_term  <= tri_prod[TRI_W:1];
                r_rem   <= r_wd;
                r_fresh <= 1'b1;
            end else begin
                r_term  <= '0;
                r_rem   <= rem_after;
                r_fresh <= 1'b0;
            end
        end
        if (i_cmd.eval) begin
            if (cost_fin < r_smallest) begin
                r_smallest <= cost_fin;
                r_best     <= r_wd;
            end
            r_wd <= r_wd + BW'(1);
        end
    end

    // result register
    always_comb begin
        if (r_ovf)               status_c = ST_OVFL;
        else if (r_words == '0)  status_c = ST_BLANK;
        else if (r_best == '0)   status_c = ST_NOFIT;
        else                     status_c = ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_status <= status_c;
            r_out_best   <= (status_c == ST_OK) ? r_best : '0;
            r_out_cost   <= (status_c == ST_OK) ? CRW'(r_smallest) : '0;
        end
    end

    assign o_best_width = r_out_best;
    assign o_least_cost = r_out_cost;
    assign o_status     = r_out_status;

endmodule
